[rtl/paged_work_queue_assert.svh]
// Assertion macros for the paged work queue.
`ifndef PAGED_WORK_QUEUE_ASSERT_SVH
`define PAGED_WORK_QUEUE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PWQ_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PWQ_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/pwq_pkg.sv]
// Package for the paged work queue: sizes, codes, payload and control types.
package pwq_pkg;
  localparam int PageEntries = 128;
  localparam int PageCount   = 16;
  localparam int SlotCount   = PageEntries * PageCount;
  localparam int EntW        = $clog2(PageEntries);
  localparam int PgW         = $clog2(PageCount);
  localparam int PgRefW      = PgW + 1;
  localparam int FillW       = $clog2(PageEntries + 1);
  localparam int SlotW       = PgW + EntW;
  localparam int TotW        = 12;
  localparam int TopW        = $clog2(PageCount + 1);

  localparam logic [1:0] OpPush = 2'd0;
  localparam logic [1:0] OpPop  = 2'd1;
  localparam logic [1:0] OpPeek = 2'd2;
  localparam logic [1:0] OpNop  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] entry_type;
    logic signed [63:0] entry_context;
    logic signed [63:0] entry_context_two;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_type;
    logic signed [63:0] out_context;
    logic signed [63:0] out_context_two;
    logic [TotW-1:0]    queued_total;
  } out_item_t;

  typedef enum logic [1:0] {
    SIdle,
    SExec,
    SOut
  } state_e;

  typedef struct packed {
    logic load;   // capture input item, start slot reads
    logic exec;   // decide and update, form result
  } cmd_t;

  typedef struct packed {
    logic dummy_ready;
  } sts_t;
endpackage

[rtl/pwq_ctrl.sv]
// Sequencer for the paged work queue: accept, execute, deliver.
module pwq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  pwq_pkg::sts_t  sts_i,
  output pwq_pkg::cmd_t  cmd_o
);
  pwq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pwq_pkg::SIdle;
    else         state_q <= state_d;
  end

  // Output holds until taken; a new item may be accepted in the same edge.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwq_pkg::SIdle: if (in_valid_i) state_d = pwq_pkg::SExec;
      pwq_pkg::SExec: state_d = pwq_pkg::SOut;
      pwq_pkg::SOut:  if (!out_stall_i) state_d = in_valid_i ? pwq_pkg::SExec : pwq_pkg::SIdle;
      default:        state_d = pwq_pkg::SIdle;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      pwq_pkg::SIdle: in_stall_o = !sts_i.dummy_ready;
      pwq_pkg::SExec: ;
      pwq_pkg::SOut: begin
        out_valid_o = 1'b1;
        in_stall_o  = out_stall_i;
      end
      default: ;
    endcase
    cmd_o.load = in_valid_i && !in_stall_o;
    cmd_o.exec = (state_q == pwq_pkg::SExec);
  end
endmodule

[rtl/pwq_data.sv]
// Datapath: entry memories, page metadata, free stack and result register.
module pwq_data (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwq_pkg::cmd_t      cmd_i,
  output pwq_pkg::sts_t      sts_o,
  input  pwq_pkg::in_item_t  in_i,
  output pwq_pkg::out_item_t out_o
);
  localparam int PE = pwq_pkg::PageEntries;
  localparam int PC = pwq_pkg::PageCount;
  localparam logic [pwq_pkg::PgRefW-1:0] NoPage = pwq_pkg::PgRefW'(PC);
  localparam logic [pwq_pkg::FillW-1:0]  FullFill = pwq_pkg::FillW'(PE);

  logic [31:0] type_mem [pwq_pkg::SlotCount];
  logic [63:0] ctx_mem  [pwq_pkg::SlotCount];
  logic [63:0] ctx2_mem [pwq_pkg::SlotCount];
  logic [pwq_pkg::FillW-1:0]  fill_q [PC];
  logic [pwq_pkg::PgRefW-1:0] link_q [PC];
  logic [pwq_pkg::PgW-1:0]    stack_q [PC];
  logic [pwq_pkg::TopW-1:0]   top_q;
  logic [pwq_pkg::PgRefW-1:0] head_q, tail_q;
  logic [pwq_pkg::TotW-1:0]   total_q;
  pwq_pkg::in_item_t          item_q;
  pwq_pkg::out_item_t         res_q, res_d;
  logic [31:0] rd_type_q;
  logic [63:0] rd_ctx_q, rd_ctx2_q;

  assign sts_o.dummy_ready = 1'b1;
  assign out_o = res_q;

  // Read slot: last entry of head page; head and fill are stable at load.
  logic [pwq_pkg::PgW-1:0]   hp;
  logic [pwq_pkg::FillW-1:0] hfill;
  logic [pwq_pkg::SlotW-1:0] rd_slot;
  assign hp      = head_q[pwq_pkg::PgW-1:0];
  assign hfill   = fill_q[hp];
  assign rd_slot = {hp, pwq_pkg::EntW'(hfill - pwq_pkg::FillW'(1))};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q    <= in_i;
      rd_type_q <= type_mem[rd_slot];
      rd_ctx_q  <= ctx_mem[rd_slot];
      rd_ctx2_q <= ctx2_mem[rd_slot];
    end
  end

  // Push decision.
  logic                        need_pg, full;
  logic [pwq_pkg::PgW-1:0]     np, tp, wpg;
  logic [pwq_pkg::FillW-1:0]   wfill;
  logic [pwq_pkg::SlotW-1:0]   wr_slot;
  logic                        do_push, do_pop, hv, nonempty;
  assign tp      = tail_q[pwq_pkg::PgW-1:0];
  assign need_pg = (tail_q == NoPage) || (fill_q[tp] >= FullFill);
  assign full    = need_pg && (top_q == '0);
  assign np      = stack_q[pwq_pkg::PgW'(top_q - pwq_pkg::TopW'(1))];
  assign wpg     = need_pg ? np : tp;
  assign wfill   = need_pg ? '0 : fill_q[tp];
  assign wr_slot = {wpg, wfill[pwq_pkg::EntW-1:0]};
  assign hv       = (head_q != NoPage);
  assign nonempty = (total_q != '0) && hv && (hfill != '0);
  assign do_push  = cmd_i.exec && item_q.opcode == pwq_pkg::OpPush && !full;
  assign do_pop   = cmd_i.exec && item_q.opcode == pwq_pkg::OpPop && nonempty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      type_mem[wr_slot] <= item_q.entry_type;
      ctx_mem[wr_slot]  <= item_q.entry_context;
      ctx2_mem[wr_slot] <= item_q.entry_context_two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fill_q[wpg] <= wfill + pwq_pkg::FillW'(1);
      if (need_pg) begin
        link_q[np] <= NoPage;
        if (tail_q != NoPage) link_q[tp] <= {1'b0, np};
      end
    end else if (do_pop) begin
      fill_q[hp] <= hfill - pwq_pkg::FillW'(1);
    end
  end

  // Free stack: entry i holds page i after reset; a drained head is pushed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PC; i++) stack_q[i] <= pwq_pkg::PgW'(i);
    end else if (do_pop && hfill == pwq_pkg::FillW'(1) && top_q < pwq_pkg::TopW'(PC)) begin
      stack_q[top_q[pwq_pkg::PgW-1:0]] <= hp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= pwq_pkg::TopW'(PC);
      head_q  <= NoPage;
      tail_q  <= NoPage;
      total_q <= '0;
    end else if (do_push) begin
      total_q <= total_q + pwq_pkg::TotW'(1);
      if (need_pg) begin
        top_q  <= top_q - pwq_pkg::TopW'(1);
        tail_q <= {1'b0, np};
        if (!hv) head_q <= {1'b0, np};
      end
    end else if (do_pop) begin
      total_q <= total_q - pwq_pkg::TotW'(1);
      if (hfill == pwq_pkg::FillW'(1)) begin
        if (top_q < pwq_pkg::TopW'(PC)) top_q <= top_q + pwq_pkg::TopW'(1);
        if (head_q == tail_q) begin
          tail_q <= NoPage;
          head_q <= NoPage;
        end else begin
          head_q <= link_q[hp];
        end
      end
    end
  end

  logic [pwq_pkg::TotW-1:0] tot_after;
  always_comb begin
    tot_after = total_q;
    if (do_push) tot_after = total_q + pwq_pkg::TotW'(1);
    else if (do_pop) tot_after = total_q - pwq_pkg::TotW'(1);
  end

  always_comb begin
    res_d = '0;
    res_d.queued_total = tot_after;
    unique case (item_q.opcode)
      pwq_pkg::OpPush: if (full) res_d.status = pwq_pkg::StFull;
      pwq_pkg::OpPop, pwq_pkg::OpPeek: begin
        if (!nonempty) res_d.status = pwq_pkg::StEmpty;
        else begin
          res_d.out_type        = rd_type_q;
          res_d.out_context     = rd_ctx_q;
          res_d.out_context_two = rd_ctx2_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= res_d;
  end
endmodule

[rtl/paged_work_queue.sv]
// Top level of the paged work queue: sequencer plus datapath.
// Each item has a load step, which captures it and reads the head entry into
// registers, and an execute step that updates pages, free stack and counters
// and loads the result register. The result register holds a finished item
// while the next item is accepted. Pops take the newest entry of the oldest
// page; a drained head page returns to the free pool. No clearing pass after
// reset: entry memories and page metadata are written before they are read.
`include "paged_work_queue_assert.svh"
module paged_work_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pwq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pwq_pkg::out_item_t out_item_o
);
  pwq_pkg::cmd_t cmd;
  pwq_pkg::sts_t sts;

  pwq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pwq_data u_data (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_i(in_item_i), .out_o(out_item_o)
  );

  `PWQ_ASSERT_NXT(a_load_exec, clk_i, rst_ni, cmd.load, cmd.exec)
  `PWQ_ASSERT_IMP(a_no_both, clk_i, rst_ni, cmd.exec, !cmd.load && !out_valid_o)
  `PWQ_ASSERT_NXT(a_exec_out, clk_i, rst_ni, cmd.exec, out_valid_o)
endmodule
